FILE: rtl/rdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions for the radix digit converter
// Field widths, base limits, transfer structs, divider handshake structs and
// the sequencer state type.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Field widths fixed by the item formats.
    localparam int NumberWidth = 31;
    localparam int RadixWidth  = 6;
    localparam int DigitWidth  = 6;

    // Default depth of the digit stack.
    localparam int StackDepthDefault = 32;

    // Range of accepted bases.
    localparam logic [RadixWidth-1:0] RadixMin = 6'd2;
    localparam logic [RadixWidth-1:0] RadixMax = 6'd36;

    // One input transfer.
    typedef struct packed {
        logic [NumberWidth-1:0] number;
        logic [RadixWidth-1:0]  radix;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic [DigitWidth-1:0] digit;
        logic                  last;
        logic                  bad_radix;
    } t_out_item;

    // Request to the shared divider.
    typedef struct packed {
        logic                   start;
        logic [NumberWidth-1:0] dividend;
        logic [RadixWidth-1:0]  divisor;
    } t_div_req;

    // Response from the shared divider.
    typedef struct packed {
        logic                   done;
        logic [NumberWidth-1:0] quotient;
        logic [DigitWidth-1:0]  remainder;
    } t_div_rsp;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_POP_ADDR,
        S_POP_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/rdc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/rdc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_div: iterative restoring divider
// Divides the working number by the base, one quotient bit per cycle, and
// pulses done with the quotient and remainder.
// ----------------------------------------------------------------------------
module rdc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rdc_pkg::t_div_req i_req,
    output      rdc_pkg::t_div_rsp o_rsp
);

    localparam int W    = rdc_pkg::NumberWidth;
    localparam int RW   = rdc_pkg::DigitWidth;
    localparam int CntW = $clog2(W);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [W-1:0]    r_q, n_q;
    logic [RW-1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_div, n_div;
    logic [RW:0]     trial;
    logic [RW:0]     diff;
    logic            ge;

    // One shift-and-subtract step on the partial remainder.
    always_comb begin
        trial = {r_rem, r_q[W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    // Step control: load on start, iterate W times, then flag completion.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_q   = {r_q[W-2:0], ge};
            n_rem = ge ? diff[RW-1:0] : trial[RW-1:0];
            n_cnt = r_cnt + CntW'(1);
            if (r_cnt == CntW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers take the reset; the data path does not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule
`default_nettype wire

FILE: rtl/radix_digit_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_converter_core: radix conversion by repeated division
// Divides a number by a base until the quotient is zero, stacks the
// remainders and emits them most significant digit first.
//
//   Channel  Signals                     Transfer when
//   input    start, busy, i_item         start high and busy low at a clock edge
//   result   o_strobe, o_result          o_strobe high, a one-cycle strobe per result
//
// Each digit takes one pass through the shared divider (a load, a shift-and-subtract
// step per number bit, a completion flag), and each pop takes an address state and
// an output state for the registered stack read. A bad base gives its single
// result in the cycle after the transfer; a zero number gives none. Reset is
// synchronous and active low and needs no clearing pass. The receiver cannot
// stall: every result is shown for one cycle.
// ----------------------------------------------------------------------------
module radix_digit_converter_core #(
    parameter int STACK_DEPTH = rdc_pkg::StackDepthDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire rdc_pkg::t_in_item  i_item,
    output      logic               o_strobe,
    output      rdc_pkg::t_out_item o_result
);

    localparam int SpW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int W   = rdc_pkg::NumberWidth;
    localparam int DW  = rdc_pkg::DigitWidth;

    rdc_pkg::t_state    r_state, n_state;
    logic [SpW-1:0]     r_sp, n_sp;
    logic [W-1:0]       r_quot, n_quot;
    logic [rdc_pkg::RadixWidth-1:0] r_radix, n_radix;
    logic               r_strobe, n_strobe;
    rdc_pkg::t_out_item r_result, n_result;

    rdc_pkg::t_div_req  div_req;
    rdc_pkg::t_div_rsp  div_rsp;

    logic               accept;
    logic               radix_ok;
    logic               ram_we;
    logic [SpW-1:0]     sp_dec;
    logic [DW-1:0]      ram_rdata;

    // Input transfer and base check.
    always_comb begin
        accept   = start && !busy;
        radix_ok = i_item.radix inside {[rdc_pkg::RadixMin:rdc_pkg::RadixMax]};
        sp_dec   = r_sp - SpW'(1);
    end

    assign busy = (r_state != rdc_pkg::S_IDLE);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rdc_pkg::S_IDLE: begin
                if (accept && radix_ok && (i_item.number != '0)) begin
                    n_state = rdc_pkg::S_DIV_START;
                end
            end
            rdc_pkg::S_DIV_START: begin
                n_state = rdc_pkg::S_DIV_WAIT;
            end
            rdc_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (div_rsp.quotient == '0) ? rdc_pkg::S_POP_ADDR
                                                       : rdc_pkg::S_DIV_START;
                end
            end
            rdc_pkg::S_POP_ADDR: begin
                n_state = rdc_pkg::S_POP_OUT;
            end
            rdc_pkg::S_POP_OUT: begin
                n_state = (r_sp == '0) ? rdc_pkg::S_IDLE : rdc_pkg::S_POP_ADDR;
            end
            default: begin
                n_state = rdc_pkg::S_IDLE;
            end
        endcase
    end

    // Output and data path control of the sequencer.
    always_comb begin
        n_sp             = r_sp;
        n_quot           = r_quot;
        n_radix          = r_radix;
        n_strobe         = 1'b0;
        n_result         = r_result;
        ram_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_quot;
        div_req.divisor  = r_radix;
        case (r_state)
            rdc_pkg::S_IDLE: begin
                if (accept) begin
                    n_radix = i_item.radix;
                    n_sp    = '0;
                    if (!radix_ok) begin
                        n_quot             = '0;
                        n_strobe           = 1'b1;
                        n_result.digit     = '0;
                        n_result.last      = 1'b1;
                        n_result.bad_radix = 1'b1;
                    end else begin
                        n_quot = i_item.number;
                    end
                end
            end
            rdc_pkg::S_DIV_START: begin
                div_req.start = 1'b1;
            end
            rdc_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_quot = div_rsp.quotient;
                    // A full stack drops the remainder.
                    if (r_sp < SpW'(STACK_DEPTH)) begin
                        ram_we = 1'b1;
                        n_sp   = r_sp + SpW'(1);
                    end
                end
            end
            rdc_pkg::S_POP_ADDR: begin
                n_sp = sp_dec;
            end
            rdc_pkg::S_POP_OUT: begin
                n_strobe           = 1'b1;
                n_result.digit     = ram_rdata;
                n_result.last      = (r_sp == '0);
                n_result.bad_radix = 1'b0;
            end
            default: begin
                n_sp = '0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rdc_pkg::S_IDLE;
            r_sp     <= '0;
            r_quot   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_quot   <= n_quot;
            r_strobe <= n_strobe;
        end
        r_radix  <= n_radix;
        r_result <= n_result;
    end

    // Shared divider.
    rdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Digit stack: pushed at the pointer, popped one below it.
    rdc_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sp[AW-1:0]),
        .i_wdata (div_rsp.remainder),
        .i_raddr (sp_dec[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

FILE: rtl/rdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_checker: port-level checks for the radix digit converter
// Watches the transfers at the top level and is bound to it.
// ----------------------------------------------------------------------------
module rdc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire rdc_pkg::t_in_item  i_item,
    input wire logic               o_strobe,
    input wire rdc_pkg::t_out_item o_result
);

    logic in_xfer;
    logic good_radix;

    assign in_xfer    = start && !busy;
    assign good_radix = (i_item.radix >= rdc_pkg::RadixMin) &&
                        (i_item.radix <= rdc_pkg::RadixMax);

    // A bad base is answered in the next cycle by a single flagged result.
    a_bad_radix_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !good_radix |=> o_strobe && o_result.bad_radix && o_result.last)
        else $error("bad base transfer not answered by a flagged result");

    // A flagged result carries a zero digit and ends its run.
    a_bad_radix_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.bad_radix |-> o_result.last && (o_result.digit == '0))
        else $error("flagged result is not a zero final digit");

    // A transfer of a nonzero number with a good base starts a run, so the block turns busy.
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && good_radix && (i_item.number != '0) |=> busy)
        else $error("conversion run did not start");

    // More digits follow while a result that is not the last is shown.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("run ended without a final digit");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire

FILE: verif/radix_digit_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_core_tb: self-checking bench for the radix converter
// Drives numbers and bases through the command port. For each accepted
// transfer, a scoreboard works out the digit sequence by repeated division.
// Every result strobe is then compared field by field with the oldest
// expected digit. The run starts with directed corner cases and continues
// with random items in phases with different amounts of sender idling.
// ----------------------------------------------------------------------------
module radix_digit_converter_core_tb;

    import rdc_pkg::*;

    // Scoreboard: predicts the digits of each accepted number and checks results.
    class digit_scoreboard;
        t_out_item digits_due[$];
        int        n_items;
        int        n_digits;
        int        n_bad_radix;
        int        n_zero;
        int        n_errors;

        function int pending();
            return digits_due.size();
        endfunction

        // Work out the result sequence of one accepted transfer.
        function void note_item(t_in_item item);
            logic [NumberWidth-1:0] quot;
            logic [RadixWidth-1:0]  base;
            logic [DigitWidth-1:0]  rems[$];
            t_out_item              res;
            int                     idx;
            base = item.radix;
            quot = item.number;
            n_items++;
            if (base < RadixMin || base > RadixMax) begin
                // An unusable base gives a single flagged result and no digits.
                res.digit     = '0;
                res.last      = 1'b1;
                res.bad_radix = 1'b1;
                digits_due.push_back(res);
                n_bad_radix++;
                return;
            end
            if (quot == '0) begin
                n_zero++;
            end
            // Remainders come out least significant first.
            while (quot != '0) begin
                rems.push_back(DigitWidth'(quot % base));
                quot = quot / base;
            end
            for (idx = rems.size() - 1; idx >= 0; idx--) begin
                res.digit     = rems[idx];
                res.last      = (idx == 0);
                res.bad_radix = 1'b0;
                digits_due.push_back(res);
            end
        endfunction

        // Compare one result with the oldest expected digit.
        function void check_result(t_out_item got);
            t_out_item want;
            if (digits_due.size() == 0) begin
                $error("result with nothing expected: digit=%0d last=%0b bad_radix=%0b",
                       got.digit, got.last, got.bad_radix);
                n_errors++;
                return;
            end
            want = digits_due.pop_front();
            n_digits++;
            if (got.digit !== want.digit) begin
                $error("digit: expected %0d, actual %0d", want.digit, got.digit);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                n_errors++;
            end
            if (got.bad_radix !== want.bad_radix) begin
                $error("bad_radix: expected %0b, actual %0b", want.bad_radix, got.bad_radix);
                n_errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    digit_scoreboard sb = new();

    radix_digit_converter_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Results are taken at the rising edge, before the block updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_result);
        end
    end

    // Offer one item, holding start low in a share of the cycles, until it transfers.
    task automatic send_item(input t_in_item item, input int idle_pct);
        logic offer;
        logic taken;
        taken  = 1'b0;
        i_item <= item;
        while (!taken) begin
            offer = ($urandom_range(99) >= idle_pct);
            start <= offer;
            @(posedge i_clk);
            taken = offer && !busy;
            if (!taken) begin
                @(negedge i_clk);
            end
        end
        sb.note_item(item);
        @(negedge i_clk);
    endtask

    // Stop offering items until every expected result has been seen.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        // A zero number produces nothing, so allow the block time to settle.
        repeat (64) @(negedge i_clk);
    endtask

    function automatic t_in_item make_item(input int unsigned num, input int unsigned base);
        t_in_item item;
        item.number = NumberWidth'(num);
        item.radix  = RadixWidth'(base);
        return item;
    endfunction

    // Random item: mostly good bases and numbers of varied length.
    function automatic t_in_item random_item();
        t_in_item    item;
        int unsigned len;
        len = $urandom_range(NumberWidth, 1);
        item.number = NumberWidth'($urandom) & ((NumberWidth'(1) << len) - 1'b1);
        if (len == NumberWidth) begin
            item.number = NumberWidth'($urandom);
        end
        if ($urandom_range(99) < 5) begin
            item.number = '0;
        end
        if ($urandom_range(99) < 85) begin
            item.radix = RadixWidth'($urandom_range(RadixMax, RadixMin));
        end else if ($urandom_range(1) == 0) begin
            item.radix = RadixWidth'($urandom_range(1, 0));
        end else begin
            item.radix = RadixWidth'($urandom_range(63, RadixMax + 1));
        end
        return item;
    endfunction

    // Main stimulus.
    initial begin
        int idle_pct[3];
        int phase;
        int k;
        idle_pct[0] = 0;
        idle_pct[1] = 63;
        idle_pct[2] = 12;

        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corner cases: widest numbers, extreme bases, zero and bad bases.
        send_item(make_item(32'h7FFF_FFFF, 2), 0);
        send_item(make_item(32'h7FFF_FFFF, 36), 0);
        send_item(make_item(32'h7FFF_FFFF, 10), 0);
        send_item(make_item(0, 10), 0);
        send_item(make_item(0, 0), 0);
        send_item(make_item(1, 2), 0);
        send_item(make_item(1, 36), 0);
        send_item(make_item(35, 36), 0);
        send_item(make_item(36, 36), 0);
        send_item(make_item(1024, 2), 0);
        send_item(make_item(12345, 0), 0);
        send_item(make_item(12345, 1), 0);
        send_item(make_item(12345, 37), 0);
        send_item(make_item(32'h7FFF_FFFF, 63), 0);
        send_item(make_item(32'h2AAA_AAAA, 2), 0);
        send_item(make_item(32'h5555_5555, 3), 0);
        send_item(make_item(99999, 10), 0);
        send_item(make_item(0, 36), 0);
        drain();

        // Random phases, each ended by a full drain.
        for (phase = 0; phase < 3; phase++) begin
            for (k = 0; k < 64; k++) begin
                send_item(random_item(), idle_pct[phase]);
            end
            drain();
        end

        $display("Covered %0d items: %0d results, %0d bad bases, %0d zero numbers.",
                 sb.n_items, sb.n_digits, sb.n_bad_radix, sb.n_zero);
        if (sb.n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: radix_digit_converter_core.f
rtl/rdc_pkg.sv
rtl/rdc_ram.sv
rtl/rdc_div.sv
rtl/radix_digit_converter_core.sv
rtl/rdc_checker.sv
verif/radix_digit_converter_core_tb.sv
